// ===== design/double_hash_table_engine_macros.svh =====
// assertion macros for the hash table engine checker
`ifndef DOUBLE_HASH_TABLE_ENGINE_MACROS_SVH
`define DOUBLE_HASH_TABLE_ENGINE_MACROS_SVH
// property that holds outside reset, on the aclk and aresetn of the using scope
`define DHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// property checked also during reset
`define DHT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`endif

// ===== design/dht_pkg.sv =====
// package: types, constants and codes of the hash table engine
package dht_pkg;
    localparam int MaxLog2Default = 10;
    localparam int HashWidth = 32;
    localparam int MinLog2 = 4;
    localparam logic [31:0] Golden = 32'h9E3779B9;
    localparam logic [3:0] Log2Reset = 4'd10;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_ADD = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [2:0] ST_HIT = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_REMOVED = 3'd3;
    localparam logic [2:0] ST_FULL = 3'd4;

    typedef struct packed {
        logic [1:0] cmd;
        logic [31:0] key;
        logic [31:0] value;
    } dht_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] slot_index;
        logic [31:0] stored_value;
        logic [9:0] live_count;
    } dht_out_t;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_START, S_READ, S_EXAM, S_WRITE, S_VREAD, S_VWAIT, S_DONE
    } dht_state_t;

    typedef enum logic [1:0] {
        OP_NONE, OP_INSERT, OP_REMOVE
    } dht_op_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic load;
        logic hash;
        logic start;
        logic read;
        logic exam;
        logic commit;
        logic vread;
        logic finish;
        logic out_take;
    } dht_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic is_add;
        logic is_lookup_rm;
        logic full;
        logic stop;
        logic need_write;
        logic need_vread;
        logic out_valid;
    } dht_stat_t;
endpackage

// ===== design/double_hash_table_engine.sv =====
// top level: open-addressed hash table engine with double hashing
// One command at a time: a beat is taken only while no result is waiting. After
// the input beat the key is hashed, then each probed slot passes through read,
// compare and mark, and write states; when the stored payload is returned it is
// read out before the result is registered. The next beat is taken only after
// the result has been taken. A refused add or an unused command probes nothing.
// After reset and after every table_log2 write a clearing pass zeroes all
// 2^MAX_LOG2 entries of the hash store before commands are taken.
module double_hash_table_engine import dht_pkg::*; #(
    parameter int MAX_LOG2 = MaxLog2Default
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_we,
    input  logic [3:0] cfg_wdata,
    input  logic s_valid,
    output logic s_ready,
    input  dht_in_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output dht_out_t m_data
);
    dht_cmd_t ctl;
    dht_stat_t stat;

    dht_controller u_ctrl (
        .aclk, .aresetn, .cfg_wr(cfg_we), .s_valid, .s_ready, .m_ready, .stat, .ctl
    );

    dht_datapath #(.MAX_LOG2(MAX_LOG2)) u_dp (
        .aclk, .aresetn, .in_data(s_data), .cfg_wr(cfg_we), .cfg_data(cfg_wdata),
        .ctl, .stat, .out_data(m_data)
    );

    assign m_valid = stat.out_valid;
endmodule

// ===== design/dht_datapath.sv =====
// datapath: hash, probe registers, slot memories, counts and result register
module dht_datapath import dht_pkg::*; #(
    parameter int MAX_LOG2 = MaxLog2Default
) (
    input  logic aclk,
    input  logic aresetn,
    input  dht_in_t in_data,
    input  logic cfg_wr,
    input  logic [3:0] cfg_data,
    input  dht_cmd_t ctl,
    output dht_stat_t stat,
    output dht_out_t out_data
);
    localparam int Depth = 1 << MAX_LOG2;
    localparam int CW = MAX_LOG2 + 1;

    logic [HashWidth-1:0] hash_mem [Depth];
    logic [31:0] key_mem [Depth];
    logic [31:0] val_mem [Depth];

    logic [3:0] log2_reg;
    logic [MAX_LOG2-1:0] clr_reg;
    dht_in_t item_reg;
    logic [31:0] h_reg, prod_reg;
    logic [MAX_LOG2-1:0] idx_reg, step_reg, first_reg, res_idx_reg;
    logic have_first_reg;
    logic [CW-1:0] n_reg, occ_reg, tomb_reg;
    logic [31:0] e_reg, k_reg, v_reg;
    logic stop_reg, hit_reg, wr_reg, vrd_reg, outv_reg;
    dht_op_t op_reg;
    logic [2:0] status_reg;
    dht_out_t out_reg;

    logic [4:0] l;
    logic [MAX_LOG2-1:0] mask;
    logic [CW-1:0] size;
    logic [31:0] hm, h2;
    logic [63:0] shl;
    logic full_now;
    logic tomb_tgt;

    always_comb begin
        l = {1'b0, log2_reg};
        if (log2_reg < 4'(MinLog2)) l = 5'(MinLog2);
        if (32'(log2_reg) > 32'(MAX_LOG2)) l = 5'(MAX_LOG2);
        size = CW'(1) << l;
        mask = MAX_LOG2'(size - CW'(1));
        hm = prod_reg;
        if (hm < 32'd2) hm = hm - 32'd2;
        h2 = {hm[31:1], 1'b0};
        shl = {32'd0, h_reg} << l;
    end

    assign full_now = (item_reg.cmd == CMD_ADD) && (occ_reg + tomb_reg >= size - CW'(1));
    // insert target is a tombstone
    assign tomb_tgt = have_first_reg || (e_reg == 32'd1);

    logic [31:0] e_cur;
    assign e_cur = e_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log2_reg <= Log2Reset;
            clr_reg <= '0;
            occ_reg <= '0;
            tomb_reg <= '0;
            outv_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                log2_reg <= cfg_data;
                occ_reg <= '0;
                tomb_reg <= '0;
                clr_reg <= '0;
            end else if (ctl.clear_en) begin
                clr_reg <= clr_reg + MAX_LOG2'(1);
            end
            if (ctl.out_take) outv_reg <= 1'b0;
            if (ctl.finish) outv_reg <= 1'b1;
            if (ctl.commit && !cfg_wr) begin
                case (op_reg)
                    OP_INSERT: begin
                        occ_reg <= occ_reg + CW'(1);
                        if (tomb_tgt) tomb_reg <= tomb_reg - CW'(1);
                    end
                    OP_REMOVE: begin
                        occ_reg <= occ_reg - CW'(1);
                        if (e_reg[0]) tomb_reg <= tomb_reg + CW'(1);
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.clear_en) hash_mem[clr_reg] <= '0;
        if (ctl.load) item_reg <= in_data;
        if (ctl.load) prod_reg <= in_data.key * Golden;
        if (ctl.hash) h_reg <= h2;
        if (ctl.start) begin
            idx_reg <= MAX_LOG2'(h_reg >> (6'd32 - 6'(l))) & mask;
            step_reg <= (MAX_LOG2'(shl[31:0] >> (6'd32 - 6'(l))) & mask) | MAX_LOG2'(1);
            have_first_reg <= 1'b0;
            first_reg <= '0;
            n_reg <= '0;
            stop_reg <= 1'b0;
            hit_reg <= 1'b0;
            wr_reg <= 1'b0;
            vrd_reg <= 1'b0;
            op_reg <= OP_NONE;
            status_reg <= full_now ? ST_FULL : ST_NOT_FOUND;
            res_idx_reg <= '0;
        end
        if (ctl.read) begin
            e_reg <= hash_mem[idx_reg];
            k_reg <= key_mem[idx_reg];
        end
        if (ctl.exam) begin
            n_reg <= n_reg + CW'(1);
            if (e_cur == 32'd0) begin
                stop_reg <= 1'b1;
                if (item_reg.cmd == CMD_ADD) begin
                    res_idx_reg <= have_first_reg ? first_reg : idx_reg;
                    idx_reg <= have_first_reg ? first_reg : idx_reg;
                    op_reg <= OP_INSERT;
                    wr_reg <= 1'b1;
                    status_reg <= ST_INSERTED;
                end
            end else if ({e_cur[31:1], 1'b0} == h_reg && k_reg == item_reg.key) begin
                stop_reg <= 1'b1;
                hit_reg <= 1'b1;
                res_idx_reg <= idx_reg;
                vrd_reg <= 1'b1;
                if (item_reg.cmd == CMD_REMOVE) begin
                    op_reg <= OP_REMOVE;
                    wr_reg <= 1'b1;
                    status_reg <= ST_REMOVED;
                end else begin
                    status_reg <= ST_HIT;
                end
            end else begin
                if (e_cur == 32'd1) begin
                    if (!have_first_reg) begin
                        have_first_reg <= 1'b1;
                        first_reg <= idx_reg;
                    end
                end else if (item_reg.cmd == CMD_ADD && !e_cur[0]) begin
                    hash_mem[idx_reg] <= e_cur | 32'd1;
                end
                if (n_reg + CW'(1) == size) begin
                    stop_reg <= 1'b1;
                    if (item_reg.cmd == CMD_ADD) begin
                        if (have_first_reg || e_cur == 32'd1) begin
                            res_idx_reg <= have_first_reg ? first_reg : idx_reg;
                            idx_reg <= have_first_reg ? first_reg : idx_reg;
                            op_reg <= OP_INSERT;
                            wr_reg <= 1'b1;
                            status_reg <= ST_INSERTED;
                        end else begin
                            status_reg <= ST_FULL;
                        end
                    end
                end else begin
                    idx_reg <= (idx_reg - step_reg) & mask;
                end
            end
        end
        if (ctl.commit) begin
            case (op_reg)
                OP_INSERT: begin
                    hash_mem[idx_reg] <= tomb_tgt ? (h_reg | 32'd1) : h_reg;
                    key_mem[idx_reg] <= item_reg.key;
                    val_mem[idx_reg] <= item_reg.value;
                end
                OP_REMOVE: hash_mem[idx_reg] <= e_reg[0] ? 32'd1 : 32'd0;
                default: ;
            endcase
        end
        if (ctl.vread) v_reg <= val_mem[res_idx_reg];
    end

    // result assembly
    dht_out_t res;
    always_comb begin
        res.status = status_reg;
        res.slot_index = 10'(res_idx_reg);
        res.stored_value = 32'd0;
        if (status_reg == ST_INSERTED) res.stored_value = item_reg.value;
        if (hit_reg) res.stored_value = v_reg;
        res.live_count = 10'(occ_reg);
    end

    always_ff @(posedge aclk) begin
        if (ctl.finish) out_reg <= res;
    end

    assign out_data = out_reg;
    assign stat.clear_last = (clr_reg == MAX_LOG2'(Depth - 1));
    assign stat.is_add = (item_reg.cmd == CMD_ADD);
    assign stat.is_lookup_rm = (item_reg.cmd == CMD_LOOKUP) || (item_reg.cmd == CMD_REMOVE);
    assign stat.full = full_now;
    assign stat.stop = stop_reg;
    assign stat.need_write = wr_reg;
    assign stat.need_vread = vrd_reg;
    assign stat.out_valid = outv_reg;
endmodule

// ===== design/dht_controller.sv =====
// controller: state machine sequencing the clear sweep and the probe
module dht_controller import dht_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic cfg_wr,
    input  logic s_valid,
    output logic s_ready,
    input  logic m_ready,
    input  dht_stat_t stat,
    output dht_cmd_t ctl
);
    dht_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_wr) state_reg <= S_CLEAR;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (stat.clear_last) state_next = S_IDLE;
            S_IDLE: if (s_valid && !stat.out_valid) state_next = S_HASH;
            S_HASH: state_next = S_START;
            S_START: begin
                if (stat.full) state_next = S_DONE;
                else if (stat.is_add || stat.is_lookup_rm) state_next = S_READ;
                else state_next = S_DONE;
            end
            S_READ: state_next = S_EXAM;
            S_EXAM: state_next = S_WRITE;
            S_WRITE: begin
                if (!stat.stop) state_next = S_READ;
                else if (stat.need_vread) state_next = S_VREAD;
                else state_next = S_DONE;
            end
            S_VREAD: state_next = S_VWAIT;
            S_VWAIT: state_next = S_DONE;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        ctl = '0;
        s_ready = 1'b0;
        ctl.out_take = stat.out_valid && m_ready;
        case (state_reg)
            S_CLEAR: ctl.clear_en = 1'b1;
            S_IDLE: begin
                s_ready = !stat.out_valid;
                ctl.load = s_valid && !stat.out_valid;
            end
            S_HASH: ctl.hash = 1'b1;
            S_START: ctl.start = 1'b1;
            S_READ: ctl.read = 1'b1;
            S_EXAM: ctl.exam = 1'b1;
            S_WRITE: ctl.commit = stat.stop && stat.need_write;
            S_VREAD: ctl.vread = 1'b1;
            S_VWAIT: ;
            S_DONE: ctl.finish = 1'b1;
            default: ;
        endcase
    end
endmodule

// ===== design/dht_checker.sv =====
// checker: port level properties of the hash table engine
`include "double_hash_table_engine_macros.svh"
module dht_port_checker import dht_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input dht_out_t m_data
);
    `DHT_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result dropped")
    `DHT_ASSERT(a_one, s_valid && s_ready |=> !s_ready, "second beat taken while busy")
    `DHT_ASSERT(a_excl, !(s_ready && m_valid), "input taken while result pending")
    `DHT_ASSERT(a_status, m_valid |-> m_data.status <= ST_FULL, "bad status code")
endmodule

bind double_hash_table_engine dht_port_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_data
);
